// ----- src/pidts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidts_pkg
// Shared types and constants of the PID step block with term selection.
// ----------------------------------------------------------------------------
package pidts_pkg;

    localparam int GAIN_W    = 16;  // signed Q8.8 gains
    localparam int STEP_W    = 16;  // unsigned Q0.16 step time
    localparam int CHUNK_W   = 16;  // operand slice handled per multiplier pass
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 32;
    localparam int FRAC_SH   = 16;  // scale of dt and of the derivative numerator
    localparam int OUT_SH    = 8;   // gain fraction bits

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TERM_MODE  = 2'd0,
        REG_PROP_GAIN  = 2'd1,
        REG_INTEG_GAIN = 2'd2,
        REG_DERIV_GAIN = 2'd3
    } t_cfg_reg;

    localparam logic [MODE_W-1:0] MODE_P   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_I   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_D   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PI  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ID  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PD  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_PID = 3'd6;

    typedef struct packed {
        logic p;
        logic i;
        logic d;
    } t_term_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_INTEG,
        S_IMUL,
        S_PMUL,
        S_DWAIT,
        S_DMUL,
        S_DONE
    } t_state;

    function automatic t_term_sel term_select(input logic [MODE_W-1:0] mode);
        t_term_sel sel;
        unique case (mode)
            MODE_P:  sel = '{p: 1'b1, i: 1'b0, d: 1'b0};
            MODE_I:  sel = '{p: 1'b0, i: 1'b1, d: 1'b0};
            MODE_D:  sel = '{p: 1'b0, i: 1'b0, d: 1'b1};
            MODE_PI: sel = '{p: 1'b1, i: 1'b1, d: 1'b0};
            MODE_ID: sel = '{p: 1'b0, i: 1'b1, d: 1'b1};
            MODE_PD: sel = '{p: 1'b1, i: 1'b0, d: 1'b1};
            default: sel = '{p: 1'b1, i: 1'b1, d: 1'b1};
        endcase
        return sel;
    endfunction

endpackage

// ----- src/pid_step_with_term_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_step_with_term_select
// Fixed-point PID step: integral with saturation, derivative by serial
// division, gain-weighted sum with mode-selected terms, saturated output.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      i_in_valid / o_in_ready   target, measured, step time
//  out      output     o_out_valid / i_out_ready drive, zero-step, saturated
//  cfg      input      i_cfg_valid / o_cfg_ready register index, write data
//
//  A new item is taken only after the last one has been written to the output
//  register and the sequencer is back in idle. The serial divider for the
//  derivative (SAMPLE_WIDTH + 17 quotient bits) sets the pace, and the shared
//  17 x 17 multiplier works through its slices while it runs.
//  The input side is ready only when the sequencer is idle. A finished result
//  sits in the output register, so the next item may be taken while it waits.
//  Synchronous reset clears state, integral, last error, config and handshake.
// ----------------------------------------------------------------------------
module pid_step_with_term_select
    import pidts_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_target_value,
    input  logic signed [SAMPLE_WIDTH-1:0] i_measured_value,
    input  logic        [STEP_W-1:0]       i_step_time,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [OUT_W-1:0]        o_drive_value,
    output logic                           o_zero_step_flag,
    output logic                           o_saturated_flag,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic        [GAIN_W-1:0]       i_cfg_data
);

    localparam int ERR_W   = SAMPLE_WIDTH + 1;
    localparam int DIFF_W  = SAMPLE_WIDTH + 2;
    localparam int DER_W   = DIFF_W + FRAC_SH;
    localparam int PROD_W  = ERR_W + STEP_W + 1;
    localparam int SUM_W   = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
    localparam int N_ERR   = (ERR_W + CHUNK_W - 1) / CHUNK_W;
    localparam int N_ACC   = (ACC_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int N_DER   = (DER_W + CHUNK_W - 1) / CHUNK_W;
    localparam int N_MAX0  = (N_ERR > N_ACC) ? N_ERR : N_ACC;
    localparam int N_MAX   = (N_MAX0 > N_DER) ? N_MAX0 : N_DER;
    localparam int OP_W    = CHUNK_W * N_MAX;
    localparam int CNT_W   = $clog2(N_MAX + 1);
    localparam int SH_W    = $clog2(FRAC_SH + CHUNK_W * N_MAX + 1);
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = CHUNK_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int T_I_W   = GAIN_W + ACC_WIDTH;
    localparam int T_D_W   = GAIN_W + DER_W + FRAC_SH;
    localparam int T_W     = ((T_I_W > T_D_W) ? T_I_W : T_D_W) + 2;
    localparam int OUT_LSB = FRAC_SH + OUT_SH;
    localparam int UP_W    = T_W - OUT_LSB - OUT_W + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W - ACC_WIDTH + 1){1'b1}}, {(ACC_WIDTH - 1){1'b0}}};
    localparam logic signed [OUT_W-1:0] DRV_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] DRV_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    // Configuration registers
    logic        [MODE_W-1:0]  r_mode;
    logic signed [GAIN_W-1:0]  r_kp;
    logic signed [GAIN_W-1:0]  r_ki;
    logic signed [GAIN_W-1:0]  r_kd;

    // Controller state and sequencer
    t_state                    r_state,     n_state;
    logic signed [ACC_WIDTH-1:0] r_es,      n_es;
    logic signed [ERR_W-1:0]   r_last_err,  n_last_err;
    logic signed [ERR_W-1:0]   r_err,       n_err;
    logic        [STEP_W-1:0]  r_dt,        n_dt;
    t_term_sel                 r_sel,       n_sel;
    logic                      r_sat,       n_sat;

    // Shared multiplier datapath
    logic signed [OP_W-1:0]    r_op,        n_op;
    logic signed [MUL_A_W-1:0] r_mul_a,     n_mul_a;
    logic        [CNT_W-1:0]   r_chunk,     n_chunk;
    logic        [CNT_W-1:0]   r_last_chunk, n_last_chunk;
    logic        [SH_W-1:0]    r_shamt,     n_shamt;
    logic signed [MUL_P_W-1:0] r_prod;
    logic        [SH_W-1:0]    r_pshamt;
    logic                      r_pvld,      n_pvld;
    logic signed [T_W-1:0]     r_acc,       n_acc;

    // Output register
    logic                      r_out_valid, n_out_valid;
    logic signed [OUT_W-1:0]   r_drive,     n_drive;
    logic                      r_zflag,     n_zflag;
    logic                      r_sflag,     n_sflag;

    logic signed [ERR_W-1:0]   err_now;
    logic signed [DIFF_W-1:0]  diff_now;
    logic signed [MUL_B_W-1:0] chunk_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [T_W-1:0]     prod_ext;
    logic signed [T_W-1:0]     prod_sh;
    logic signed [PROD_W-1:0]  integ_prod;
    logic signed [SUM_W-1:0]   integ_sum;
    logic        [UP_W-1:0]    drv_upper;
    logic                      drv_ovf;
    logic                      div_start;
    logic                      div_busy;
    logic signed [DER_W-1:0]   div_quot;

    assign err_now  = ERR_W'(i_target_value) - ERR_W'(i_measured_value);
    assign diff_now = DIFF_W'(err_now) - DIFF_W'(r_last_err);

    pidts_div #(
        .DIFF_W (DIFF_W),
        .DEN_W  (STEP_W),
        .SHIFT  (FRAC_SH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_diff  (diff_now),
        .i_den   (i_step_time),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // The top slice of an operand carries its sign; lower slices are unsigned.
    assign chunk_b = (r_chunk == r_last_chunk) ?
                     {r_op[CHUNK_W-1], r_op[CHUNK_W-1:0]} :
                     {1'b0, r_op[CHUNK_W-1:0]};
    assign mul_p   = r_mul_a * chunk_b;
    assign prod_ext = T_W'(r_prod);
    assign prod_sh  = prod_ext <<< r_pshamt;

    assign integ_prod = r_acc[PROD_W-1:0];
    assign integ_sum  = SUM_W'(r_es) + SUM_W'(integ_prod);

    // The accumulator holds the total scaled by 2^(FRAC_SH + OUT_SH).
    assign drv_upper = r_acc[T_W-1:OUT_LSB+OUT_W-1];
    assign drv_ovf   = !((&drv_upper) || (~|drv_upper));

    always_comb begin
        n_state      = r_state;
        n_es         = r_es;
        n_last_err   = r_last_err;
        n_err        = r_err;
        n_dt         = r_dt;
        n_sel        = r_sel;
        n_sat        = r_sat;
        n_op         = r_op;
        n_mul_a      = r_mul_a;
        n_chunk      = r_chunk;
        n_last_chunk = r_last_chunk;
        n_shamt      = r_shamt;
        n_pvld       = 1'b0;
        n_acc        = r_pvld ? (r_acc + prod_sh) : r_acc;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_drive      = r_drive;
        n_zflag      = r_zflag;
        n_sflag      = r_sflag;
        div_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    div_start    = 1'b1;
                    n_err        = err_now;
                    n_last_err   = err_now;
                    n_dt         = i_step_time;
                    n_sel        = term_select(r_mode);
                    n_sat        = 1'b0;
                    n_acc        = '0;
                    n_op         = OP_W'(err_now);
                    n_mul_a      = {1'b0, i_step_time};
                    n_chunk      = '0;
                    n_last_chunk = CNT_W'(N_ERR - 1);
                    n_shamt      = '0;
                    n_state      = S_PROD;
                end
            end
            S_PROD, S_IMUL, S_PMUL, S_DMUL: begin
                n_pvld  = 1'b1;
                n_op    = r_op >>> CHUNK_W;
                n_chunk = r_chunk + 1'b1;
                n_shamt = r_shamt + SH_W'(CHUNK_W);
                if (r_chunk == r_last_chunk) begin
                    priority if (r_state == S_PROD) begin
                        n_state = S_INTEG;
                    end else if (r_state == S_IMUL) begin
                        n_op         = OP_W'(r_err);
                        n_mul_a      = r_sel.p ? MUL_A_W'(r_kp) : '0;
                        n_chunk      = '0;
                        n_last_chunk = CNT_W'(N_ERR - 1);
                        n_shamt      = SH_W'(FRAC_SH);
                        n_state      = S_PMUL;
                    end else if (r_state == S_PMUL) begin
                        n_state = S_DWAIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INTEG: begin
                // Wait for the last error * dt slice to land in the accumulator.
                if (!r_pvld) begin
                    if (integ_sum > SUM_MAX) begin
                        n_es  = SUM_MAX[ACC_WIDTH-1:0];
                        n_sat = 1'b1;
                    end else if (integ_sum < SUM_MIN) begin
                        n_es  = SUM_MIN[ACC_WIDTH-1:0];
                        n_sat = 1'b1;
                    end else begin
                        n_es  = integ_sum[ACC_WIDTH-1:0];
                    end
                    n_acc        = '0;
                    n_op         = OP_W'(n_es);
                    n_mul_a      = r_sel.i ? MUL_A_W'(r_ki) : '0;
                    n_chunk      = '0;
                    n_last_chunk = CNT_W'(N_ACC - 1);
                    n_shamt      = '0;
                    n_state      = S_IMUL;
                end
            end
            S_DWAIT: begin
                if (!div_busy) begin
                    n_op         = OP_W'(div_quot);
                    n_mul_a      = r_sel.d ? MUL_A_W'(r_kd) : '0;
                    n_chunk      = '0;
                    n_last_chunk = CNT_W'(N_DER - 1);
                    n_shamt      = SH_W'(FRAC_SH);
                    n_state      = S_DMUL;
                end
            end
            S_DONE: begin
                if (!r_pvld && (!r_out_valid || i_out_ready)) begin
                    n_out_valid = 1'b1;
                    n_zflag     = (r_dt == '0);
                    n_sflag     = r_sat || drv_ovf;
                    if (drv_ovf) begin
                        n_drive = r_acc[T_W-1] ? DRV_MIN : DRV_MAX;
                    end else begin
                        n_drive = r_acc[OUT_LSB+OUT_W-1:OUT_LSB];
                    end
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_es        <= '0;
            r_last_err  <= '0;
            r_pvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_es        <= n_es;
            r_last_err  <= n_last_err;
            r_pvld      <= n_pvld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err        <= n_err;
        r_dt         <= n_dt;
        r_sel        <= n_sel;
        r_sat        <= n_sat;
        r_op         <= n_op;
        r_mul_a      <= n_mul_a;
        r_chunk      <= n_chunk;
        r_last_chunk <= n_last_chunk;
        r_shamt      <= n_shamt;
        r_prod       <= mul_p;
        r_pshamt     <= r_shamt;
        r_acc        <= n_acc;
        r_drive      <= n_drive;
        r_zflag      <= n_zflag;
        r_sflag      <= n_sflag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PID;
            r_kp   <= '0;
            r_ki   <= '0;
            r_kd   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_TERM_MODE:  r_mode <= i_cfg_data[MODE_W-1:0];
                REG_PROP_GAIN:  r_kp   <= i_cfg_data;
                REG_INTEG_GAIN: r_ki   <= i_cfg_data;
                REG_DERIV_GAIN: r_kd   <= i_cfg_data;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_drive_value    = r_drive;
    assign o_zero_step_flag = r_zflag;
    assign o_saturated_flag = r_sflag;

endmodule

// ----- src/pidts_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidts_div
// Serial restoring divider for the derivative: (diff * 2^SHIFT) / den,
// truncated toward zero, one quotient bit per cycle. A zero divisor gives 0.
// ----------------------------------------------------------------------------
module pidts_div #(
    parameter int DIFF_W = 18,
    parameter int DEN_W  = 16,
    parameter int SHIFT  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [DIFF_W-1:0]              i_diff,
    input  logic        [DEN_W-1:0]               i_den,
    output logic                                  o_busy,
    output logic signed [DIFF_W+SHIFT-1:0]        o_quot
);

    localparam int MAG_W = DIFF_W - 1 + SHIFT;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DEN_W-1:0]     r_den;
    logic                 r_neg;
    logic                 r_zero;
    logic [DEN_W-1:0]     r_rem;
    logic [MAG_W-1:0]     r_quo;

    logic signed [DIFF_W-1:0] diff_abs;
    logic [MAG_W-1:0]         mag;
    logic [DEN_W:0]           rem_sh;
    logic [DEN_W+1:0]         trial;
    logic                     q_bit;
    logic signed [MAG_W:0]    quo_pos;

    // The magnitude of the difference always fits in DIFF_W-1 bits.
    assign diff_abs = i_diff[DIFF_W-1] ? -i_diff : i_diff;
    assign mag      = {diff_abs[DIFF_W-2:0], {SHIFT{1'b0}}};

    assign rem_sh = {r_rem, r_quo[MAG_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_den};
    assign q_bit  = ~trial[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(MAG_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_neg  <= i_diff[DIFF_W-1];
            r_zero <= (i_den == '0);
            r_rem  <= '0;
            r_quo  <= mag;
        end else if (r_busy) begin
            r_rem  <= q_bit ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo  <= {r_quo[MAG_W-2:0], q_bit};
        end
    end

    assign quo_pos = {1'b0, r_quo};
    assign o_busy  = r_busy;
    assign o_quot  = r_zero ? '0 : (r_neg ? -quo_pos : quo_pos);

endmodule
